// ===== design/ssl_pkg.sv =====
// Shared types and codes for the stack signature lookup.
// No dependencies; used by every module of the block but ssl_ram.
package ssl_pkg;

    localparam int IDX_W   = 7;
    localparam int FRAME_W = 64;
    localparam int MTDATA_W = 16;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_FULL = 2'd1,
        ERR_DEEP = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_POST
    } t_state;

    typedef struct packed {
        logic start;
        logic last;
    } t_sweep_ctl;

    typedef struct packed {
        logic done;
        logic hit;
    } t_sweep_stat;

    typedef struct packed {
        t_kind              kind;
        logic               found;
        logic [IDX_W-1:0]   index;
        t_err               error;
    } t_result;

endpackage

// ===== design/ssl_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Uses no package.
module ssl_ram #(
    parameter int WIDTH = 64,
    parameter int WORDS = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(WORDS)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(WORDS)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [WORDS];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/ssl_sweep.sv =====
// Entry scan for one query beat: reads every stored entry at the frame's
// position, updates its match bit and tracks the lowest full match.
// Depends on ssl_pkg.
module ssl_sweep #(
    parameter int ENTRIES = 128,
    parameter int DEPTH   = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ssl_pkg::t_sweep_ctl                i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0]         i_pos,
    input  logic [ssl_pkg::FRAME_W-1:0]        i_frame,
    input  logic [$clog2(ENTRIES+1)-1:0]       i_count,
    output ssl_pkg::t_sweep_stat               o_stat,
    output logic [$clog2(ENTRIES)-1:0]         o_where,
    output logic [$clog2(ENTRIES*DEPTH)-1:0]   o_fs_raddr,
    input  logic [ssl_pkg::FRAME_W-1:0]        i_fs_rdata,
    output logic [$clog2(ENTRIES)-1:0]         o_em_raddr,
    input  logic [$clog2(DEPTH+1):0]           i_em_rdata,
    output logic                               o_em_we,
    output logic [$clog2(ENTRIES)-1:0]         o_em_waddr,
    output logic [$clog2(DEPTH+1):0]           o_em_wdata
);
    import ssl_pkg::*;

    localparam int EW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES+1);
    localparam int PW = $clog2(DEPTH+1);
    localparam int AW = $clog2(ENTRIES*DEPTH);

    logic               r_busy;
    logic [EW-1:0]      r_e;
    logic [AW-1:0]      r_base;
    logic               r_rd_v;
    logic [EW-1:0]      r_rd_e;
    logic [PW-1:0]      r_p;
    logic [FRAME_W-1:0] r_frame;
    logic               r_last;
    logic               r_hit;
    logic [EW-1:0]      r_where;

    logic [PW:0]   p1;
    logic [PW:0]   dext;
    logic          old_match;
    logic          mismatch;
    logic          new_match;
    logic          hit_now;

    always_comb begin
        p1        = {1'b0, r_p} + (PW+1)'(1);
        dext      = {1'b0, i_em_rdata[PW-1:0]};
        old_match = (r_p == '0) ? 1'b1 : i_em_rdata[PW];
        mismatch  = (r_p != '0) && (p1 < dext) && (i_fs_rdata != r_frame);
        new_match = old_match && !mismatch;
        hit_now   = r_rd_v && r_last && new_match && (dext == p1) && !r_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rd_v <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            r_rd_v <= r_busy;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_hit  <= 1'b0;
            end else if (r_busy && (CW'(r_e) + CW'(1) == i_count)) begin
                r_busy <= 1'b0;
            end
            if (hit_now) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_e <= r_e;
        if (i_ctl.start) begin
            r_e     <= '0;
            r_base  <= '0;
            r_p     <= i_pos;
            r_frame <= i_frame;
            r_last  <= i_ctl.last;
            r_where <= '0;
        end else if (r_busy) begin
            r_e    <= r_e + EW'(1);
            r_base <= r_base + AW'(DEPTH);
        end
        if (hit_now) begin
            r_where <= r_rd_e;
        end
    end

    assign o_fs_raddr  = r_base + AW'(r_p);
    assign o_em_raddr  = r_e;
    assign o_em_we     = r_rd_v;
    assign o_em_waddr  = r_rd_e;
    assign o_em_wdata  = {new_match, i_em_rdata[PW-1:0]};
    assign o_stat      = '{done: r_rd_v && !r_busy, hit: r_hit || hit_now};
    assign o_where     = hit_now ? r_rd_e : r_where;

endmodule

// ===== design/stack_signature_lookup.sv =====
// Top level of the stack signature lookup: beat decode, load path, result
// register and the two memories (frame store, entry depth with match bit).
// Depends on ssl_pkg, ssl_ram and ssl_sweep.
//
//  channel | dir | tdata               | tuser | tlast
//  s       | in  | frame[63:0]         | mode  | last
//  m       | out | found,index,error   | kind  | -
//
// Load beats, clear beats and query beats past DEPTH are taken in IDLE; every
// clear beat and every stack's last beat post a result through POST. A query
// frame reads every stored entry once from the frame store and entry table.
// Reset is synchronous and needs no clearing pass; stored frames and depths
// are only read below entry_count. A stalled m side holds one result in the
// output register while the next beat is taken; a second result waits.
module stack_signature_lookup #(
    parameter int ENTRIES = 128,
    parameter int DEPTH   = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [ssl_pkg::FRAME_W-1:0]    i_s_tdata,   // [63:0] frame
    input  logic [1:0]                     i_s_tuser,   // [1:0] mode
    input  logic                           i_s_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [ssl_pkg::MTDATA_W-1:0]   o_m_tdata,   // [0] found, [7:1] index,
                                                        // [9:8] error
    output logic [1:0]                     o_m_tuser    // [1:0] kind
);
    import ssl_pkg::*;

    localparam int EW  = $clog2(ENTRIES);
    localparam int CW  = $clog2(ENTRIES+1);
    localparam int PW  = $clog2(DEPTH+1);
    localparam int AW  = $clog2(ENTRIES*DEPTH);
    localparam int EMW = PW + 1;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [AW-1:0]  r_load_base, n_load_base;
    logic [PW-1:0]  r_pos, n_pos;
    logic           r_ovf, n_ovf;
    logic           r_open_q, n_open_q;
    logic           r_last_q, n_last_q;
    t_result        r_res, n_res;
    logic           r_out_valid, n_out_valid;
    t_result        r_out, n_out;

    t_mode          mode;
    logic           accept;
    logic           is_q;
    logic           chg;
    logic [PW-1:0]  p_eff;
    logic           ov_eff;
    logic           in_range;
    logic           has_room;

    logic             fs_we;
    logic [AW-1:0]    fs_waddr;
    logic [FRAME_W-1:0] fs_rdata;
    logic [AW-1:0]    fs_raddr;

    logic             ld_em_we;
    logic             em_we;
    logic [EW-1:0]    em_waddr;
    logic [EMW-1:0]   em_wdata;
    logic [EW-1:0]    em_raddr;
    logic [EMW-1:0]   em_rdata;
    logic             sw_em_we;
    logic [EW-1:0]    sw_em_waddr;
    logic [EMW-1:0]   sw_em_wdata;

    t_sweep_ctl       sw_ctl;
    t_sweep_stat      sw_stat;
    logic [EW-1:0]    sw_where;

    assign mode       = t_mode'(i_s_tuser);
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign is_q       = (mode == MODE_QUERY);
    assign chg        = ((r_pos != '0) || r_ovf) && (r_open_q != is_q);
    assign p_eff      = chg ? '0 : r_pos;
    assign ov_eff     = chg ? 1'b0 : r_ovf;
    assign in_range   = (p_eff < PW'(DEPTH));
    assign has_room   = (r_count < CW'(ENTRIES));
    assign fs_waddr   = r_load_base + AW'(p_eff);
    assign fs_we      = accept && (mode == MODE_LOAD) && in_range && has_room;
    assign ld_em_we   = accept && (mode == MODE_LOAD) && i_s_tlast && has_room
                        && in_range;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_load_base = r_load_base;
        n_pos       = r_pos;
        n_ovf       = r_ovf;
        n_open_q    = r_open_q;
        n_last_q    = r_last_q;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        sw_ctl      = '0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept && (mode == MODE_CLEAR)) begin
                    n_count     = '0;
                    n_load_base = '0;
                    n_pos       = '0;
                    n_ovf       = 1'b0;
                    n_res       = '{KIND_CLEAR, 1'b0, '0, ERR_NONE};
                    n_state     = S_POST;
                end else if (accept && (mode == MODE_LOAD || mode == MODE_QUERY)) begin
                    n_open_q = is_q;
                    n_pos    = in_range ? p_eff + PW'(1) : p_eff;
                    n_ovf    = ov_eff || !in_range;
                    n_last_q = i_s_tlast;
                    if (!is_q) begin
                        if (i_s_tlast) begin
                            n_state = S_POST;
                            if (!has_room) begin
                                n_res = '{KIND_LOAD, 1'b0, '0, ERR_FULL};
                            end else if (n_ovf) begin
                                n_res = '{KIND_LOAD, 1'b0, '0, ERR_DEEP};
                            end else begin
                                n_res       = '{KIND_LOAD, 1'b0, IDX_W'(r_count), ERR_NONE};
                                n_count     = r_count + CW'(1);
                                n_load_base = r_load_base + AW'(DEPTH);
                            end
                        end
                    end else if (in_range && (r_count != '0)) begin
                        sw_ctl.start = 1'b1;
                        sw_ctl.last  = i_s_tlast;
                        n_state      = S_SWEEP;
                    end else if (i_s_tlast) begin
                        n_res   = '{KIND_QUERY, 1'b0, '0, n_ovf ? ERR_DEEP : ERR_NONE};
                        n_state = S_POST;
                    end
                    if (i_s_tlast) begin
                        n_pos = '0;
                        n_ovf = 1'b0;
                    end
                end
            end
            S_SWEEP: begin
                if (sw_stat.done) begin
                    if (r_last_q) begin
                        n_res   = '{KIND_QUERY, sw_stat.hit,
                                    sw_stat.hit ? IDX_W'(sw_where) : '0, ERR_NONE};
                        n_state = S_POST;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_POST: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_load_base <= '0;
            r_pos       <= '0;
            r_ovf       <= 1'b0;
            r_open_q    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_load_base <= n_load_base;
            r_pos       <= n_pos;
            r_ovf       <= n_ovf;
            r_open_q    <= n_open_q;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_q <= n_last_q;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign em_we    = sw_em_we || ld_em_we;
    assign em_waddr = sw_em_we ? sw_em_waddr : r_count[EW-1:0];
    assign em_wdata = sw_em_we ? sw_em_wdata : {1'b1, p_eff + PW'(1)};

    ssl_ram #(
        .WIDTH (FRAME_W),
        .WORDS (ENTRIES*DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (fs_we),
        .i_waddr (fs_waddr),
        .i_wdata (i_s_tdata),
        .i_raddr (fs_raddr),
        .o_rdata (fs_rdata)
    );

    ssl_ram #(
        .WIDTH (EMW),
        .WORDS (ENTRIES)
    ) u_entry_table (
        .i_clk   (i_clk),
        .i_we    (em_we),
        .i_waddr (em_waddr),
        .i_wdata (em_wdata),
        .i_raddr (em_raddr),
        .o_rdata (em_rdata)
    );

    ssl_sweep #(
        .ENTRIES (ENTRIES),
        .DEPTH   (DEPTH)
    ) u_sweep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (sw_ctl),
        .i_pos      (p_eff),
        .i_frame    (i_s_tdata),
        .i_count    (r_count),
        .o_stat     (sw_stat),
        .o_where    (sw_where),
        .o_fs_raddr (fs_raddr),
        .i_fs_rdata (fs_rdata),
        .o_em_raddr (em_raddr),
        .i_em_rdata (em_rdata),
        .o_em_we    (sw_em_we),
        .o_em_waddr (sw_em_waddr),
        .o_em_wdata (sw_em_wdata)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = MTDATA_W'({r_out.error, r_out.index, r_out.found});

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("entry count beyond table size");

    a_ovf_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_pos == PW'(DEPTH)))
        else $error("overflow flag without full position");

    a_no_load_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> !(fs_we || ld_em_we))
        else $error("load write during entry scan");

    a_post_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POST) && (!r_out_valid || i_m_tready) |=> o_m_tvalid)
        else $error("result lost at post");

    a_done_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sw_stat.done |-> (r_state == S_SWEEP))
        else $error("scan finished outside scan state");

endmodule

// ===== sim/ssl_checker.sv =====
// Checker for the stack signature lookup: watches both stream channels, predicts
// every result from the accepted input beats and compares them in order.
// Depends on ssl_pkg for the mode, kind and error codes and the result layout.
module ssl_checker #(
    parameter int ENTRIES = 128,
    parameter int DEPTH   = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [ssl_pkg::FRAME_W-1:0]   i_s_tdata,   // [63:0] frame
    input  logic [1:0]                    i_s_tuser,   // [1:0] mode
    input  logic                          i_s_tlast,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [ssl_pkg::MTDATA_W-1:0]  i_m_tdata,   // [0] found, [7:1] index,
                                                       // [9:8] error
    input  logic [1:0]                    i_m_tuser,   // [1:0] kind
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked,
    output int                            o_hits
);
    timeunit 1ns;
    timeprecision 1ps;
    import ssl_pkg::*;

    logic [FRAME_W-1:0] sig_frames [ENTRIES][DEPTH];
    int                 sig_len [ENTRIES];
    int                 sig_count;
    int                 open_pos;
    bit                 live [ENTRIES];
    bit                 too_deep;
    t_mode              open_mode;
    t_result            answers_due [$];
    int                 fails;
    int                 checked;
    int                 hits;

    function automatic void drop_stack();
        open_pos = 0;
        too_deep = 1'b0;
        foreach (live[e]) live[e] = 1'b1;
    endfunction

    function automatic void absorb_beat(t_mode m, logic [FRAME_W-1:0] f, logic l);
        t_result r;
        int      where;
        r = '{kind: KIND_LOAD, found: 1'b0, index: '0, error: ERR_NONE};
        where = -1;
        if (m == MODE_NONE) return;
        if (m == MODE_CLEAR) begin
            sig_count = 0;
            drop_stack();
            r.kind = KIND_CLEAR;
            answers_due.push_back(r);
            return;
        end
        if ((open_pos != 0 || too_deep) && open_mode != m) drop_stack();
        open_mode = m;
        if (open_pos >= DEPTH) begin
            too_deep = 1'b1;
        end else begin
            if (m == MODE_LOAD) begin
                if (sig_count < ENTRIES) sig_frames[sig_count][open_pos] = f;
            end else begin
                for (int e = 0; e < sig_count; e++) begin
                    if (open_pos >= 1 && open_pos + 1 < sig_len[e] &&
                        sig_frames[e][open_pos] != f)
                        live[e] = 1'b0;
                end
            end
            open_pos++;
        end
        if (!l) return;
        if (m == MODE_LOAD) begin
            if (sig_count >= ENTRIES) begin
                r.error = ERR_FULL;
            end else if (too_deep) begin
                r.error = ERR_DEEP;
            end else begin
                sig_len[sig_count] = open_pos;
                r.index = IDX_W'(sig_count);
                sig_count++;
            end
        end else begin
            r.kind = KIND_QUERY;
            if (too_deep) begin
                r.error = ERR_DEEP;
            end else begin
                // lowest matching index wins
                for (int e = sig_count - 1; e >= 0; e--)
                    if (live[e] && sig_len[e] == open_pos) where = e;
                if (where >= 0) begin
                    r.found = 1'b1;
                    r.index = IDX_W'(where);
                    hits++;
                end
            end
        end
        answers_due.push_back(r);
        drop_stack();
    endfunction

    function automatic void report_field(string what, logic [7:0] want, logic [7:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            sig_count = 0;
            open_mode = MODE_LOAD;
            drop_stack();
            answers_due.delete();
            fails   = 0;
            checked = 0;
            hits    = 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                absorb_beat(t_mode'(i_s_tuser), i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                got.kind  = t_kind'(i_m_tuser);
                got.found = i_m_tdata[0];
                got.index = i_m_tdata[7:1];
                got.error = t_err'(i_m_tdata[9:8]);
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, ", $time,
                             "actual kind %0d found %0d index %0d error %0d",
                             got.kind, got.found, got.index, got.error);
                    fails++;
                end else begin
                    want = answers_due.pop_front();
                    checked++;
                    if (got.kind !== want.kind) begin
                        report_field("kind", want.kind, got.kind);
                        fails++;
                    end
                    if (got.found !== want.found) begin
                        report_field("found", want.found, got.found);
                        fails++;
                    end
                    if (got.index !== want.index) begin
                        report_field("index", want.index, got.index);
                        fails++;
                    end
                    if (got.error !== want.error) begin
                        report_field("error", want.error, got.error);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= answers_due.size();
        o_checked    <= checked;
        o_hits       <= hits;
    end

endmodule

// ===== sim/stack_signature_lookup_tb.sv =====
// Testbench top for the stack signature lookup: builds load, query and clear
// beats, drives both stream handshakes with random idling and gives the verdict.
// Depends on ssl_pkg, stack_signature_lookup and ssl_checker.
module stack_signature_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssl_pkg::*;

    localparam int ENTRIES      = 128;
    localparam int DEPTH        = 64;
    localparam int BEATS_WANTED = 1100;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int TAIL         = 2 * ENTRIES + 16;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [FRAME_W-1:0]  s_tdata  = '0;
    logic [1:0]          s_tuser  = MODE_LOAD;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [MTDATA_W-1:0] m_tdata;
    logic [1:0]          m_tuser;

    int fail_count;
    int pending;
    int checked;
    int hits;

    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;
    int beats_sent  = 0;
    int stacks_sent = 0;
    int idle_count  = 0;

    logic [FRAME_W-1:0] stk [DEPTH+4];
    logic [FRAME_W-1:0] lib_frames [ENTRIES][DEPTH];
    int                 lib_len [ENTRIES];
    int                 lib_n = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stack_signature_lookup #(
        .ENTRIES(ENTRIES),
        .DEPTH  (DEPTH)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .i_s_tlast (s_tlast),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser)
    );

    ssl_checker #(
        .ENTRIES(ENTRIES),
        .DEPTH  (DEPTH)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tlast   (s_tlast),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_hits      (hits)
    );

    function automatic logic [FRAME_W-1:0] rand_frame();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_depth();
        if ($urandom_range(0, 24) == 0) return $urandom_range(DEPTH - 2, DEPTH + 2);
        return $urandom_range(1, 6);
    endfunction

    function automatic void fill_random(int n);
        for (int i = 0; i < n; i++) stk[i] = rand_frame();
    endfunction

    task automatic send_beat(input t_mode m, input logic [FRAME_W-1:0] f, input logic l);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= f;
        s_tuser  <= m;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (m != MODE_NONE) beats_sent++;
    endtask

    task automatic send_stack(input t_mode m, input int n);
        for (int i = 0; i < n; i++) begin
            // mode three beats inside a stack must leave it untouched
            if (i > 0 && $urandom_range(0, 19) == 0)
                send_beat(MODE_NONE, rand_frame(), 1'($urandom_range(0, 1)));
            send_beat(m, stk[i], i == n - 1);
        end
        if (m == MODE_LOAD && n <= DEPTH && lib_n < ENTRIES) begin
            for (int i = 0; i < n; i++) lib_frames[lib_n][i] = stk[i];
            lib_len[lib_n] = n;
            lib_n++;
        end
        stacks_sent++;
    endtask

    task automatic do_clear(input logic l);
        send_beat(MODE_CLEAR, rand_frame(), l);
        lib_n = 0;
    endtask

    task automatic query_known(input int k);
        int n;
        int mid;
        n = lib_len[k];
        for (int i = 0; i < n; i++) stk[i] = lib_frames[k][i];
        if ($urandom_range(0, 1)) begin
            stk[0]     = rand_frame();
            stk[n - 1] = rand_frame();
        end
        case ($urandom_range(0, 3))
            2: begin
                if (n >= 3) begin
                    mid = $urandom_range(1, n - 2);
                    stk[mid][$urandom_range(0, FRAME_W - 1)] ^= 1'b1;
                end
            end
            3: begin
                if (n > 1 && $urandom_range(0, 1)) begin
                    n--;
                end else begin
                    stk[n] = rand_frame();
                    n++;
                end
            end
            default: ;
        endcase
        send_stack(MODE_QUERY, n);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // result side: per-result idle draw, one long hold on request
    initial begin : rx_side
        int gap;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : tx_side
        int    pick;
        int    n;
        bit    fill_done;
        t_mode first_m;
        t_mode other_m;
        fill_done = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every mode, mode switches, several matches
        do_clear(1'b0);
        stk[0] = '1;
        send_stack(MODE_QUERY, 1);
        send_stack(MODE_LOAD, 1);
        stk[0] = '0; stk[1] = '1; stk[2] = '0;
        send_stack(MODE_LOAD, 3);
        stk[0] = '1; stk[1] = '1; stk[2] = '1;
        send_stack(MODE_QUERY, 3);
        stk[0] = '0; stk[1] = '0; stk[2] = '0;
        send_stack(MODE_QUERY, 3);
        stk[0] = '1; stk[1] = '1; stk[2] = '1;
        send_stack(MODE_LOAD, 3);
        stk[0] = rand_frame(); stk[1] = '1; stk[2] = rand_frame();
        send_stack(MODE_QUERY, 3);
        send_beat(MODE_LOAD, rand_frame(), 1'b0);
        send_beat(MODE_LOAD, rand_frame(), 1'b0);
        fill_random(2);
        send_stack(MODE_QUERY, 2);
        send_stack(MODE_LOAD, 2);
        fill_random(2);
        send_stack(MODE_QUERY, 2);
        send_beat(MODE_QUERY, rand_frame(), 1'b0);
        stk[0] = rand_frame();
        send_stack(MODE_LOAD, 1);
        send_beat(MODE_NONE, '1, 1'b1);
        send_beat(MODE_LOAD, '0, 1'b0);
        do_clear(1'b1);
        wait_drain();

        // hold the result side while single-frame loads keep coming
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++) begin
            stk[0] = rand_frame();
            send_stack(MODE_LOAD, 1);
        end
        wait_drain();

        while (beats_sent < BEATS_WANTED) begin
            if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
            if (!fill_done && beats_sent > BEATS_WANTED / 2) begin
                // over-depth stacks, then fill the table past its size
                fill_done = 1'b1;
                do_clear(1'b0);
                fill_random(DEPTH + 1);
                send_stack(MODE_LOAD, DEPTH + 1);
                fill_random(DEPTH + 2);
                send_stack(MODE_QUERY, DEPTH + 2);
                for (int i = 0; i < ENTRIES + 3; i++) begin
                    n = (i >= ENTRIES - 4) ? 3 : $urandom_range(1, 3);
                    fill_random(n);
                    send_stack(MODE_LOAD, n);
                end
                fill_random(DEPTH + 1);
                send_stack(MODE_LOAD, DEPTH + 1);
                query_known(ENTRIES - 1);
                query_known($urandom_range(0, lib_n - 1));
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                n = pick_depth();
                fill_random(n);
                send_stack(MODE_LOAD, n);
            end else if (pick < 70 && lib_n > 0) begin
                query_known($urandom_range(0, lib_n - 1));
            end else if (pick < 82) begin
                n = pick_depth();
                fill_random(n);
                send_stack(MODE_QUERY, n);
            end else if (pick < 90) begin
                // abandon an open stack by switching mode or clearing
                first_m = $urandom_range(0, 1) ? MODE_QUERY : MODE_LOAD;
                other_m = (first_m == MODE_LOAD) ? MODE_QUERY : MODE_LOAD;
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) send_beat(first_m, rand_frame(), 1'b0);
                if ($urandom_range(0, 3) == 0) begin
                    do_clear(1'($urandom_range(0, 1)));
                end else begin
                    n = $urandom_range(1, 5);
                    fill_random(n);
                    send_stack(other_m, n);
                end
            end else if (pick < 94) begin
                do_clear(1'($urandom_range(0, 1)));
            end else begin
                send_beat(MODE_NONE, rand_frame(), 1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 29) == 0) wait_drain();
        end

        wait_drain();
        repeat (TAIL) @(posedge clk);
        $display("run covered %0d beats in %0d stacks, with full-table and over-depth stacks",
                 beats_sent, stacks_sent);
        $display("%0d results compared, %0d of them query hits", checked, hits);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ssl_pkg.sv
design/ssl_ram.sv
design/ssl_sweep.sv
design/stack_signature_lookup.sv
sim/ssl_checker.sv
sim/stack_signature_lookup_tb.sv
